// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/febf_pkg.sv
// ----------------------------------------------------------------------------
// febf_pkg
// types and constants of the fene bond energy and force pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package febf_pkg;

  localparam int unsigned CFG_W         = 24;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned RSQ_W         = 32;
  localparam int unsigned LEN_W         = 24;
  localparam int unsigned SQ_W          = 2 * LEN_W;
  localparam int unsigned P_W           = CFG_W + LEN_W;
  localparam int unsigned ARG_W         = 31;
  localparam int unsigned ARG_FRAC      = 30;
  localparam int unsigned ARG_DIV_STEPS = 30;
  localparam int unsigned Q1_W          = 52;
  localparam int unsigned DR_W          = SQ_W + LEN_W;
  localparam int unsigned DR_PRE        = 8;
  localparam int unsigned LOG_STEPS     = 30;
  localparam int unsigned EXP_W         = 3;
  localparam int unsigned LOG_MAX_EXP   = 4;
  localparam int unsigned NLN_W         = 32;
  localparam int unsigned RES_W         = 32;

  localparam logic [CFG_W-1:0] MAXEXT_RESET = 24'd1048576;
  localparam logic [ARG_W-1:0] ONE_Q30      = 31'd1073741824;
  localparam logic [ARG_W-1:0] ARG_MIN_Q30  = 31'd107374182;
  localparam logic [ARG_FRAC-1:0] LN2_Q30   = 30'd744261118;
  localparam logic [RES_W-1:0] FORCE_MIN    = 32'h8000_0000;
  localparam logic [RES_W-1:0] FORCE_MAX    = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFF0  = 3'd0,
    CFG_MAXEXT0 = 3'd1,
    CFG_REST0   = 3'd2,
    CFG_STIFF1  = 3'd3,
    CFG_MAXEXT1 = 3'd4,
    CFG_REST1   = 3'd5
  } febf_cfg_e;

  typedef struct packed {
    logic             bond_type;
    logic [RSQ_W-1:0] squared_distance;
  } febf_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] bond_energy;
    logic signed [RES_W-1:0] force_over_r;
    logic                    overstretch_flag;
  } febf_out_t;

endpackage

// File: rtl/febf_sqrt.sv
// ----------------------------------------------------------------------------
// febf_sqrt
// pipelined integer square root of rsq * 2^16, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module febf_sqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [febf_pkg::RSQ_W-1:0] rsq_i,
  input  logic [SideW-1:0]           side_i,
  output logic                       valid_o,
  output logic [febf_pkg::LEN_W-1:0] root_o,
  output logic [SideW-1:0]           side_o
);
  import febf_pkg::*;

  localparam int unsigned Steps  = LEN_W;
  localparam int unsigned RemW   = LEN_W + 2;
  localparam int unsigned ShiftW = 2 * LEN_W - RSQ_W;

  logic             valid_q [Steps];
  logic [RSQ_W-1:0] rsq_q   [Steps];
  logic [LEN_W-1:0] root_q  [Steps];
  logic [RemW-1:0]  rem_q   [Steps];
  logic [SideW-1:0] side_q  [Steps];

  logic             valid_p [Steps];
  logic [RSQ_W-1:0] rsq_p   [Steps];
  logic [LEN_W-1:0] root_p  [Steps];
  logic [RemW-1:0]  rem_p   [Steps];
  logic [SideW-1:0] side_p  [Steps];

  logic [2*LEN_W-1:0] n_w     [Steps];
  logic [RemW+1:0]    t_w     [Steps];
  logic [RemW+1:0]    trial_w [Steps];
  logic               ge_w    [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - s;

    if (s == 0) begin : g_first
      assign valid_p[s] = valid_i;
      assign rsq_p[s]   = rsq_i;
      assign root_p[s]  = '0;
      assign rem_p[s]   = '0;
      assign side_p[s]  = side_i;
    end else begin : g_next
      assign valid_p[s] = valid_q[s-1];
      assign rsq_p[s]   = rsq_q[s-1];
      assign root_p[s]  = root_q[s-1];
      assign rem_p[s]   = rem_q[s-1];
      assign side_p[s]  = side_q[s-1];
    end

    assign n_w[s]     = {rsq_p[s], {ShiftW{1'b0}}};
    assign t_w[s]     = {rem_p[s], n_w[s][2*Bit +: 2]};
    assign trial_w[s] = (RemW+2)'({root_p[s], 2'b01});
    assign ge_w[s]    = t_w[s] >= trial_w[s];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_p[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rsq_q[s]  <= rsq_p[s];
      side_q[s] <= side_p[s];
      root_q[s] <= {root_p[s][LEN_W-2:0], ge_w[s]};
      if (ge_w[s]) begin
        rem_q[s] <= RemW'(t_w[s] - trial_w[s]);
      end else begin
        rem_q[s] <= t_w[s][RemW-1:0];
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// File: rtl/febf_div.sv
// ----------------------------------------------------------------------------
// febf_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module febf_div #(
  parameter int unsigned RemW  = febf_pkg::SQ_W,
  parameter int unsigned Steps = febf_pkg::ARG_DIV_STEPS,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [RemW-1:0]  den_i,
  input  logic [Steps-1:0] num_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [Steps-1:0] quo_o,
  output logic [SideW-1:0] side_o
);

  logic             valid_q [Steps];
  logic [RemW-1:0]  rem_q   [Steps];
  logic [RemW-1:0]  den_q   [Steps];
  logic [Steps-1:0] num_q   [Steps];
  logic [Steps-1:0] quo_q   [Steps];
  logic [SideW-1:0] side_q  [Steps];

  logic             valid_p [Steps];
  logic [RemW-1:0]  rem_p   [Steps];
  logic [RemW-1:0]  den_p   [Steps];
  logic [Steps-1:0] num_p   [Steps];
  logic [Steps-1:0] quo_p   [Steps];
  logic [SideW-1:0] side_p  [Steps];

  logic [RemW:0] t_w    [Steps];
  logic [RemW:0] diff_w [Steps];
  logic          ge_w   [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    if (s == 0) begin : g_first
      assign valid_p[s] = valid_i;
      assign rem_p[s]   = rem_i;
      assign den_p[s]   = den_i;
      assign num_p[s]   = num_i;
      assign quo_p[s]   = '0;
      assign side_p[s]  = side_i;
    end else begin : g_next
      assign valid_p[s] = valid_q[s-1];
      assign rem_p[s]   = rem_q[s-1];
      assign den_p[s]   = den_q[s-1];
      assign num_p[s]   = num_q[s-1];
      assign quo_p[s]   = quo_q[s-1];
      assign side_p[s]  = side_q[s-1];
    end

    // bring down the next numerator bit, subtract when it fits
    assign t_w[s]    = {rem_p[s], num_p[s][Steps-1-s]};
    assign ge_w[s]   = t_w[s] >= {1'b0, den_p[s]};
    assign diff_w[s] = t_w[s] - {1'b0, den_p[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_p[s];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s]  <= den_p[s];
      num_q[s]  <= num_p[s];
      side_q[s] <= side_p[s];
      quo_q[s]  <= {quo_p[s][Steps-2:0], ge_w[s]};
      if (ge_w[s]) begin
        rem_q[s] <= diff_w[s][RemW-1:0];
      end else begin
        rem_q[s] <= t_w[s][RemW-1:0];
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// File: rtl/febf_log.sv
// ----------------------------------------------------------------------------
// febf_log
// pipelined -ln(arg) for arg in [0.1, 1.0], Q1.30 in, Q.30 out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module febf_log #(
  parameter int unsigned SideW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [febf_pkg::ARG_W-1:0] arg_i,
  input  logic [SideW-1:0]           side_i,
  output logic                       valid_o,
  output logic [febf_pkg::NLN_W-1:0] nln_o,
  output logic [SideW-1:0]           side_o
);
  import febf_pkg::*;

  localparam int unsigned Steps = LOG_STEPS;
  localparam int unsigned Nl2W  = EXP_W + ARG_FRAC;
  localparam int unsigned ProdW = Nl2W + ARG_FRAC;

  // normalize stage
  logic             nv_q;
  logic [EXP_W-1:0] ne_q;
  logic [ARG_W-1:0] nm_q;
  logic [SideW-1:0] nside_q;
  logic [EXP_W-1:0] ne_d;
  logic [ARG_W-1:0] nm_d;

  always_comb begin
    ne_d = EXP_W'(LOG_MAX_EXP);
    for (int i = LOG_MAX_EXP - 1; i >= 0; i--) begin
      if (arg_i[ARG_W-1-i]) begin
        ne_d = EXP_W'(i);
      end
    end
    nm_d = ARG_W'(arg_i << ne_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else begin
      nv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ne_q    <= ne_d;
    nm_q    <= nm_d;
    nside_q <= side_i;
  end

  // fraction bits by repeated squaring, one bit per stage
  logic                valid_q [Steps];
  logic [EXP_W-1:0]    e_q     [Steps];
  logic [ARG_W-1:0]    m_q     [Steps];
  logic [Steps-1:0]    f_q     [Steps];
  logic [SideW-1:0]    side_q  [Steps];

  logic                valid_p [Steps];
  logic [EXP_W-1:0]    e_p     [Steps];
  logic [ARG_W-1:0]    m_p     [Steps];
  logic [Steps-1:0]    f_p     [Steps];
  logic [SideW-1:0]    side_p  [Steps];

  logic [2*ARG_W-1:0]  sq_w    [Steps];
  logic [ARG_W:0]      t_w     [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    if (s == 0) begin : g_first
      assign valid_p[s] = nv_q;
      assign e_p[s]     = ne_q;
      assign m_p[s]     = nm_q;
      assign f_p[s]     = '0;
      assign side_p[s]  = nside_q;
    end else begin : g_next
      assign valid_p[s] = valid_q[s-1];
      assign e_p[s]     = e_q[s-1];
      assign m_p[s]     = m_q[s-1];
      assign f_p[s]     = f_q[s-1];
      assign side_p[s]  = side_q[s-1];
    end

    assign sq_w[s] = m_p[s] * m_p[s];
    assign t_w[s]  = sq_w[s][2*ARG_W-1:ARG_FRAC];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_p[s];
      end
    end

    always_ff @(posedge clk_i) begin
      e_q[s]    <= e_p[s];
      side_q[s] <= side_p[s];
      f_q[s]    <= {f_p[s][Steps-2:0], t_w[s][ARG_W]};
      if (t_w[s][ARG_W]) begin
        m_q[s] <= t_w[s][ARG_W:1];
      end else begin
        m_q[s] <= t_w[s][ARG_W-1:0];
      end
    end
  end

  // -log2, then scale by ln 2
  logic             lv_q;
  logic [Nl2W-1:0]  nl2_q;
  logic [SideW-1:0] lside_q;
  logic             ov_q;
  logic [NLN_W-1:0] nln_q;
  logic [SideW-1:0] oside_q;
  logic [ProdW-1:0] prod_w;

  assign prod_w = nl2_q * LN2_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      lv_q <= valid_q[Steps-1];
      ov_q <= lv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nl2_q   <= {e_q[Steps-1], {ARG_FRAC{1'b0}}} - Nl2W'(f_q[Steps-1]);
    lside_q <= side_q[Steps-1];
    nln_q   <= prod_w[ARG_FRAC +: NLN_W];
    oside_q <= lside_q;
  end

  assign valid_o = ov_q;
  assign nln_o   = nln_q;
  assign side_o  = oside_q;

endmodule

// File: rtl/fene_bond_energy_force_core.sv
// ----------------------------------------------------------------------------
// fene_bond_energy_force_core
// fene bond energy and force over length, fixed point, one bond per clock
// ----------------------------------------------------------------------------
// A bond item is taken on every clock edge where start is high; busy is never
// raised, so items may follow each other in every cycle. Each item returns one
// result on res_o, marked by result_valid_o for a single cycle, in the order
// the items were taken. There is no way to hold results back: the receiver
// must take them in the cycle they appear. The pipeline is made up of a
// 24-stage square root, a 30-stage divider for the log argument, a 33-stage
// logarithm, a 52-stage and a 32-stage divider for the force, and 9
// registers around them. Write the parameter registers only while no item
// is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fene_bond_energy_force_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  febf_pkg::febf_in_t             in_i,
  output logic                           result_valid_o,
  output febf_pkg::febf_out_t            res_o,
  input  logic                           cfg_we_i,
  input  logic [febf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [febf_pkg::CFG_W-1:0]     cfg_data_i
);
  import febf_pkg::*;

  localparam int unsigned Lat = 1 + LEN_W + 4 + ARG_DIV_STEPS + 1 + (LOG_STEPS + 3) + 1
                              + Q1_W + 1 + RES_W + 1;
  localparam int unsigned Q1Tail = Q1_W - ARG_FRAC;

  typedef struct packed {
    logic             bond_type;
    logic             pos;
    logic [P_W-1:0]   p;
    logic             flag;
    logic             fsat;
    logic             pz;
    logic [DR_W-1:0]  dr;
  } argside_t;

  typedef struct packed {
    argside_t         a;
    logic [ARG_W-1:0] arg;
  } logside_t;

  typedef struct packed {
    logic             pos;
    logic             flag;
    logic             fsat;
    logic             pz;
    logic [DR_W-1:0]  dr;
    logic [RES_W-1:0] energy;
  } fside_t;

  typedef struct packed {
    logic             pos;
    logic             flag;
    logic             fsat;
    logic             pz;
    logic             ovf;
    logic [RES_W-1:0] energy;
  } hside_t;

  // parameter registers
  logic [CFG_W-1:0] stiff0_q, stiff1_q, maxext0_q, maxext1_q, rest0_q, rest1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff0_q  <= '0;
      stiff1_q  <= '0;
      maxext0_q <= MAXEXT_RESET;
      maxext1_q <= MAXEXT_RESET;
      rest0_q   <= '0;
      rest1_q   <= '0;
    end else if (cfg_we_i) begin
      case (febf_cfg_e'(cfg_idx_i))
        CFG_STIFF0:  stiff0_q  <= cfg_data_i;
        CFG_MAXEXT0: maxext0_q <= cfg_data_i;
        CFG_REST0:   rest0_q   <= cfg_data_i;
        CFG_STIFF1:  stiff1_q  <= cfg_data_i;
        CFG_MAXEXT1: maxext1_q <= cfg_data_i;
        CFG_REST1:   rest1_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input register
  logic             v0_q;
  logic             type0_q;
  logic [RSQ_W-1:0] rsq0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    type0_q <= in_i.bond_type;
    rsq0_q  <= in_i.squared_distance;
  end

  // r = sqrt(rsq)
  logic             vS;
  logic [LEN_W-1:0] rS;
  logic             typeS;

  febf_sqrt #(
    .SideW (1)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .rsq_i   (rsq0_q),
    .side_i  (type0_q),
    .valid_o (vS),
    .root_o  (rS),
    .side_o  (typeS)
  );

  // stage a: x = r - r0 as sign and magnitude
  logic             vA_q, typeA_q, posA_q;
  logic [LEN_W-1:0] rA_q, axA_q;
  logic [CFG_W-1:0] r0_sel;
  logic             posA_d;

  assign r0_sel = typeS ? rest1_q : rest0_q;
  assign posA_d = rS > r0_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
    end else begin
      vA_q <= vS;
    end
  end

  always_ff @(posedge clk_i) begin
    typeA_q <= typeS;
    rA_q    <= rS;
    posA_q  <= posA_d;
    axA_q   <= posA_d ? (rS - r0_sel) : (r0_sel - rS);
  end

  // stage b: x^2, delta^2, k*|x|
  logic             vB_q, typeB_q, posB_q;
  logic [LEN_W-1:0] rB_q;
  logic [SQ_W-1:0]  x2B_q, d2B_q;
  logic [P_W-1:0]   pB_q;
  logic [CFG_W-1:0] kA_sel, dlA_sel;

  assign kA_sel  = typeA_q ? stiff1_q : stiff0_q;
  assign dlA_sel = typeA_q ? maxext1_q : maxext0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vB_q <= 1'b0;
    end else begin
      vB_q <= vA_q;
    end
  end

  always_ff @(posedge clk_i) begin
    typeB_q <= typeA_q;
    posB_q  <= posA_q;
    rB_q    <= rA_q;
    x2B_q   <= axA_q * axA_q;
    d2B_q   <= dlA_sel * dlA_sel;
    pB_q    <= kA_sel * axA_q;
  end

  // stage c: clamp test and partial products of delta^2 * r
  logic                vC_q, typeC_q, posC_q, flagC_q, fsatC_q, pzC_q;
  logic [SQ_W-1:0]     x2C_q, d2C_q;
  logic [P_W-1:0]      pC_q;
  logic [SQ_W-1:0]     drloC_q, drhiC_q;
  logic [SQ_W+3:0]     x2_ten, d2_nine;

  assign x2_ten  = ((SQ_W+4)'(x2B_q) << 3) + ((SQ_W+4)'(x2B_q) << 1);
  assign d2_nine = ((SQ_W+4)'(d2B_q) << 3) + (SQ_W+4)'(d2B_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vC_q <= 1'b0;
    end else begin
      vC_q <= vB_q;
    end
  end

  always_ff @(posedge clk_i) begin
    typeC_q <= typeB_q;
    posC_q  <= posB_q;
    x2C_q   <= x2B_q;
    d2C_q   <= d2B_q;
    pC_q    <= pB_q;
    flagC_q <= (d2B_q == '0) || (x2_ten > d2_nine);
    fsatC_q <= (d2B_q == '0) || (rB_q == '0);
    pzC_q   <= pB_q == '0;
    drloC_q <= d2B_q[LEN_W-1:0] * rB_q;
    drhiC_q <= d2B_q[SQ_W-1:LEN_W] * rB_q;
  end

  // stage d: sum of partial products
  logic             vD_q;
  logic [SQ_W-1:0]  x2D_q, d2D_q;
  argside_t         sideD_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vD_q <= 1'b0;
    end else begin
      vD_q <= vC_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x2D_q             <= x2C_q;
    d2D_q             <= d2C_q;
    sideD_q.bond_type <= typeC_q;
    sideD_q.pos       <= posC_q;
    sideD_q.p         <= pC_q;
    sideD_q.flag      <= flagC_q;
    sideD_q.fsat      <= fsatC_q;
    sideD_q.pz        <= pzC_q;
    sideD_q.dr        <= {drhiC_q, {LEN_W{1'b0}}} + DR_W'(drloC_q);
  end

  // x^2 / delta^2 as a Q.30 fraction
  logic                     vQ;
  logic [ARG_DIV_STEPS-1:0] quoQ;
  argside_t                 sideQ;

  febf_div #(
    .RemW  (SQ_W),
    .Steps (ARG_DIV_STEPS),
    .SideW ($bits(argside_t))
  ) u_arg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vD_q),
    .rem_i   (x2D_q),
    .den_i   (d2D_q),
    .num_i   ('0),
    .side_i  (sideD_q),
    .valid_o (vQ),
    .quo_o   (quoQ),
    .side_o  (sideQ)
  );

  // stage e: log argument with clamp
  logic             vE_q;
  logic [ARG_W-1:0] argE_q;
  argside_t         sideE_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vE_q <= 1'b0;
    end else begin
      vE_q <= vQ;
    end
  end

  always_ff @(posedge clk_i) begin
    argE_q  <= sideQ.flag ? ARG_MIN_Q30 : (ONE_Q30 - ARG_W'(quoQ));
    sideE_q <= sideQ;
  end

  // -ln(arg)
  logic             vL;
  logic [NLN_W-1:0] nlnL;
  logside_t         sideL;
  logside_t         logside_in;

  assign logside_in.a   = sideE_q;
  assign logside_in.arg = argE_q;

  febf_log #(
    .SideW ($bits(logside_t))
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vE_q),
    .arg_i   (argE_q),
    .side_i  (logside_in),
    .valid_o (vL),
    .nln_o   (nlnL),
    .side_o  (sideL)
  );

  // stage f: energy = k * -ln(arg) / 2
  logic                   vF_q;
  logic [P_W-1:0]         pF_q;
  logic [ARG_W-1:0]       argF_q;
  fside_t                 sideF_q;
  logic [CFG_W-1:0]       kL_sel;
  logic [CFG_W+NLN_W-1:0] eprod;

  assign kL_sel = sideL.a.bond_type ? stiff1_q : stiff0_q;
  assign eprod  = kL_sel * nlnL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vF_q <= 1'b0;
    end else begin
      vF_q <= vL;
    end
  end

  always_ff @(posedge clk_i) begin
    pF_q           <= sideL.a.p;
    argF_q         <= sideL.arg;
    sideF_q.pos    <= sideL.a.pos;
    sideF_q.flag   <= sideL.a.flag;
    sideF_q.fsat   <= sideL.a.fsat;
    sideF_q.pz     <= sideL.a.pz;
    sideF_q.dr     <= sideL.a.dr;
    sideF_q.energy <= RES_W'(eprod >> (ARG_FRAC + 1));
  end

  // q1 = k*|x| * 2^30 / arg
  logic            vM;
  logic [Q1_W-1:0] q1M;
  fside_t          sideM;

  febf_div #(
    .RemW  (ARG_W),
    .Steps (Q1_W),
    .SideW ($bits(fside_t))
  ) u_q1_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vF_q),
    .rem_i   (ARG_W'(pF_q >> Q1Tail)),
    .den_i   (argF_q),
    .num_i   ({pF_q[Q1Tail-1:0], {ARG_FRAC{1'b0}}}),
    .side_i  (sideF_q),
    .valid_o (vM),
    .quo_o   (q1M),
    .side_o  (sideM)
  );

  // stage g: overflow test for q1 * 2^40 / (delta^2 * r) against 2^32
  logic            vG_q;
  logic [DR_W-1:0] remG_q, drG_q;
  hside_t          sideG_q;
  logic [DR_W-1:0] q1_pre;

  assign q1_pre = DR_W'({q1M, {DR_PRE{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vG_q <= 1'b0;
    end else begin
      vG_q <= vM;
    end
  end

  always_ff @(posedge clk_i) begin
    remG_q         <= q1_pre;
    drG_q          <= sideM.dr;
    sideG_q.pos    <= sideM.pos;
    sideG_q.flag   <= sideM.flag;
    sideG_q.fsat   <= sideM.fsat;
    sideG_q.pz     <= sideM.pz;
    sideG_q.ovf    <= q1_pre >= sideM.dr;
    sideG_q.energy <= sideM.energy;
  end

  // low 32 quotient bits of the force magnitude
  logic             vN;
  logic [RES_W-1:0] qN;
  hside_t           sideN;

  febf_div #(
    .RemW  (DR_W),
    .Steps (RES_W),
    .SideW ($bits(hside_t))
  ) u_force_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vG_q),
    .rem_i   (remG_q),
    .den_i   (drG_q),
    .num_i   ('0),
    .side_i  (sideG_q),
    .valid_o (vN),
    .quo_o   (qN),
    .side_o  (sideN)
  );

  // stage h: sign and saturation
  logic             result_valid_q;
  febf_out_t        res_q;
  logic             hi_mag;
  logic [RES_W-1:0] force_d;

  assign hi_mag = sideN.fsat || sideN.ovf || qN[RES_W-1];

  always_comb begin
    if (sideN.pz) begin
      force_d = '0;
    end else if (sideN.pos) begin
      force_d = hi_mag ? FORCE_MIN : (RES_W'(0) - qN);
    end else begin
      force_d = hi_mag ? FORCE_MAX : qN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= vN;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.bond_energy      <= sideN.energy;
    res_q.force_over_r     <= force_d;
    res_q.overstretch_flag <= sideN.flag;
  end

  assign result_valid_o = result_valid_q;
  assign res_o          = res_q;

  `ASSERT_IMPLY(a_fixed_latency, result_valid_o, $past(start && !busy, Lat), "result without item")
  `ASSERT_IMPLY(a_arg_range, vE_q, (argE_q >= ARG_MIN_Q30) && (argE_q <= ONE_Q30), "log arg range")
  `ASSERT_IMPLY(a_energy_sign, result_valid_o, !res_o.bond_energy[RES_W-1], "negative energy")

endmodule
